/* hdl/two_layer_alpha_blend_unit_assert.svh */
// ----------------------------------------------------------------------------
// Two-layer alpha blend unit: assertion macros
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TWO_LAYER_ALPHA_BLEND_UNIT_ASSERT_SVH
`define TWO_LAYER_ALPHA_BLEND_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TLAB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("two_layer_alpha_blend_unit: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TLAB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("two_layer_alpha_blend_unit: assertion failed");

`else

`define TLAB_ASSERT_IMP(label, clk, rst, ante, cons)
`define TLAB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/tlab_pkg.sv */
// ----------------------------------------------------------------------------
// Two-layer alpha blend unit: package
// Shared widths, codes, pixel types and the exact divide-by-255 helper.
// ----------------------------------------------------------------------------
package tlab_pkg;

   localparam int CHAN_W     = 8;
   localparam int NUM_CH     = 4;
   localparam int ALPHA_CH   = 3;
   localparam int TERM_W     = 16;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 8;

   localparam logic [TERM_W-1:0] FULL_SQ   = 16'd65025;
   localparam logic [TERM_W-1:0] OPAQUE_88 = 16'hFF00;

   typedef enum logic [1:0] {
      MODE_PREMULT  = 2'd0,
      MODE_COVERAGE = 2'd1,
      MODE_NONE     = 2'd2,
      MODE_BYPASS   = 2'd3
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_TOP_MODE           = 8'd0,
      REG_TOP_PLANE_ALPHA    = 8'd1,
      REG_BOTTOM_MODE        = 8'd2,
      REG_BOTTOM_PLANE_ALPHA = 8'd3
   } reg_index_type;

   typedef logic [CHAN_W-1:0]           chan_type;
   typedef chan_type [NUM_CH-1:0]       pixel_type;
   typedef logic [TERM_W-1:0]           term_type;
   typedef term_type [NUM_CH-1:0]       term_set_type;

   // Exact floor(n / 255) for any 32-bit n: multiply by ceil(2^40 / 255),
   // which is 2^32 + 2^24 + 2^16 + 2^8 + 2, and keep bits 40 and up.
   function automatic logic [24:0] div255(input logic [31:0] n);
      logic [65:0] prod;
      prod = (66'(n) << 32) + (66'(n) << 24) + (66'(n) << 16)
           + (66'(n) << 8) + (66'(n) << 1);
      return prod[64:40];
   endfunction

endpackage

/* hdl/tlab_ifs.sv */
// ----------------------------------------------------------------------------
// Two-layer alpha blend unit: channel interfaces
// Request, response and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tlab_req_if;
   logic                        valid;
   logic                        ready;
   logic [tlab_pkg::CHAN_W-1:0] top_red;
   logic [tlab_pkg::CHAN_W-1:0] top_green;
   logic [tlab_pkg::CHAN_W-1:0] top_blue;
   logic [tlab_pkg::CHAN_W-1:0] top_alpha;
   logic [tlab_pkg::CHAN_W-1:0] bottom_red;
   logic [tlab_pkg::CHAN_W-1:0] bottom_green;
   logic [tlab_pkg::CHAN_W-1:0] bottom_blue;
   logic [tlab_pkg::CHAN_W-1:0] bottom_alpha;

   modport source (output valid, top_red, top_green, top_blue, top_alpha,
                   bottom_red, bottom_green, bottom_blue, bottom_alpha,
                   input ready);
   modport sink   (input valid, top_red, top_green, top_blue, top_alpha,
                   bottom_red, bottom_green, bottom_blue, bottom_alpha,
                   output ready);
endinterface

interface tlab_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tlab_pkg::CHAN_W-1:0] out_red;
   logic [tlab_pkg::CHAN_W-1:0] out_green;
   logic [tlab_pkg::CHAN_W-1:0] out_blue;
   logic [tlab_pkg::CHAN_W-1:0] out_alpha;

   modport source (output valid, out_red, out_green, out_blue, out_alpha,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha,
                   output ready);
endinterface

interface tlab_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tlab_pkg::CSR_ADDR_W-1:0] index;
   logic [tlab_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/two_layer_alpha_blend_unit.sv */
// ----------------------------------------------------------------------------
// Two-layer alpha blend unit
// Composes a bottom and a top RGBA pixel onto transparent black, per layer
// blend mode and plane alpha, in 8.8 fixed point with a saturated 8-bit result.
// ----------------------------------------------------------------------------
// Usage. Each request on req_bus carries one top and one bottom pixel; each
// response on rsp_bus carries the composed pixel, one response per request, in
// order. Both channels use valid/ready and move a request at a clock edge where
// both are high. Registers are written through csr_bus (index 0 top mode,
// 1 top plane alpha, 2 bottom mode, 3 bottom plane alpha); it is always ready,
// writes to other indices are dropped, and writes are expected only while no
// request is in flight.
// Throughput is one request per cycle while the receiver keeps taking
// responses. A request reaches the response through nine register stages: eight
// stages of multiplies and exact divisions by 255, then the final sum and saturate.
// Reset (synchronous, active high) empties the pipeline and returns the
// registers to premultiplied mode with fully opaque plane alpha.
// When the receiver stalls, the pipeline keeps accepting until every stage is
// full; any empty stage is squeezed out, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "two_layer_alpha_blend_unit_assert.svh"

module two_layer_alpha_blend_unit (
   input  logic       clock,
   input  logic       reset,
   tlab_req_if.sink   req_bus,
   tlab_rsp_if.source rsp_bus,
   tlab_csr_if.sink   csr_bus
);

   localparam int NUM_STAGES = 9;

   // Configuration registers.
   tlab_pkg::mode_type top_mode_ff;
   tlab_pkg::chan_type top_pa_ff;
   tlab_pkg::mode_type bottom_mode_ff;
   tlab_pkg::chan_type bottom_pa_ff;

   // Pipeline control: one valid bit per stage, and an advance signal that is
   // high when a stage may take new contents (empty, or its owner moves on).
   logic [NUM_STAGES:1] v_ff;
   logic [NUM_STAGES:1] adv;

   tlab_pkg::pixel_type    top_pix;
   tlab_pkg::pixel_type    bot_pix;
   tlab_pkg::term_set_type top_term;
   tlab_pkg::term_set_type bot_term;
   tlab_pkg::term_type     top_cover;
   tlab_pkg::term_type     bot_cover;

   // Stages 6 to 9: the top layer folded onto the bottom result.
   logic [tlab_pkg::NUM_CH-1:0][31:0] dw_ff;
   tlab_pkg::term_set_type            tterm6_ff;
   tlab_pkg::term_set_type            d6_ff;
   logic [tlab_pkg::NUM_CH-1:0][24:0] e1_ff;
   tlab_pkg::term_set_type            tterm7_ff;
   tlab_pkg::term_set_type            d7_ff;
   tlab_pkg::term_set_type            e2_ff;
   tlab_pkg::term_set_type            tterm8_ff;
   tlab_pkg::term_set_type            d8_ff;
   tlab_pkg::pixel_type               out_ff;

   tlab_pkg::term_type                weight;
   logic [tlab_pkg::TERM_W:0]         blend_sum [tlab_pkg::NUM_CH];

   // Register writes. The port never pushes back.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_mode_ff    <= tlab_pkg::MODE_PREMULT;
         top_pa_ff      <= 8'hFF;
         bottom_mode_ff <= tlab_pkg::MODE_PREMULT;
         bottom_pa_ff   <= 8'hFF;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            tlab_pkg::REG_TOP_MODE: begin
               top_mode_ff <= tlab_pkg::mode_type'(csr_bus.data[1:0]);
            end
            tlab_pkg::REG_TOP_PLANE_ALPHA: begin
               top_pa_ff <= csr_bus.data;
            end
            tlab_pkg::REG_BOTTOM_MODE: begin
               bottom_mode_ff <= tlab_pkg::mode_type'(csr_bus.data[1:0]);
            end
            tlab_pkg::REG_BOTTOM_PLANE_ALPHA: begin
               bottom_pa_ff <= csr_bus.data;
            end
            default: begin
            end
         endcase
      end
   end

   // A stage advances when it is empty or when the stage after it advances.
   // The last stage is the response register.
   always_comb begin
      adv[NUM_STAGES] = !v_ff[NUM_STAGES] || rsp_bus.ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req_bus.ready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[1]) begin
            v_ff[1] <= req_bus.valid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Channel order inside a pixel is red, green, blue, alpha.
   assign top_pix = {req_bus.top_alpha, req_bus.top_blue,
                     req_bus.top_green, req_bus.top_red};
   assign bot_pix = {req_bus.bottom_alpha, req_bus.bottom_blue,
                     req_bus.bottom_green, req_bus.bottom_red};

   // Both layers compute their source terms side by side in stages 1 to 5.
   // The background is transparent black, so the bottom term is already the
   // bottom result.
   tlab_layer u_top_layer (
      .clock       (clock),
      .stage_en    (adv[5:1]),
      .pixel       (top_pix),
      .plane_alpha (top_pa_ff),
      .mode        (top_mode_ff),
      .term        (top_term),
      .ap_term     (top_cover)
   );

   tlab_layer u_bottom_layer (
      .clock       (clock),
      .stage_en    (adv[5:1]),
      .pixel       (bot_pix),
      .plane_alpha (bottom_pa_ff),
      .mode        (bottom_mode_ff),
      .term        (bot_term),
      .ap_term     (bot_cover)
   );

   // The destination keeps 65025 - a*P of itself, in units of 1/65025.
   assign weight = tlab_pkg::FULL_SQ - top_cover;

   // Stage 6: destination times remaining weight.
   always_ff @(posedge clock) begin
      if (adv[6]) begin
         for (int ch = 0; ch < tlab_pkg::NUM_CH; ch++) begin
            dw_ff[ch] <= 32'(bot_term[ch]) * 32'(weight);
         end
         tterm6_ff <= top_term;
         d6_ff     <= bot_term;
      end
   end

   // Stages 7 and 8: the division by 65025 as two exact divisions by 255.
   always_ff @(posedge clock) begin
      if (adv[7]) begin
         for (int ch = 0; ch < tlab_pkg::NUM_CH; ch++) begin
            e1_ff[ch] <= tlab_pkg::div255(dw_ff[ch]);
         end
         tterm7_ff <= tterm6_ff;
         d7_ff     <= d6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         for (int ch = 0; ch < tlab_pkg::NUM_CH; ch++) begin
            e2_ff[ch] <= 16'(tlab_pkg::div255(32'(e1_ff[ch])));
         end
         tterm8_ff <= tterm7_ff;
         d8_ff     <= d7_ff;
      end
   end

   always_comb begin
      for (int ch = 0; ch < tlab_pkg::NUM_CH; ch++) begin
         blend_sum[ch] = 17'(tterm8_ff[ch]) + 17'(e2_ff[ch]);
      end
   end

   // Stage 9: the response register. A bypassed top layer shows the bottom
   // result; with no blending the top colour replaces it outright; otherwise
   // the sum saturates at the 8.8 ceiling before its integer part is taken.
   always_ff @(posedge clock) begin
      if (adv[9]) begin
         for (int ch = 0; ch < tlab_pkg::NUM_CH; ch++) begin
            case (top_mode_ff)
               tlab_pkg::MODE_NONE: begin
                  out_ff[ch] <= tterm8_ff[ch][15:8];
               end
               tlab_pkg::MODE_BYPASS: begin
                  out_ff[ch] <= d8_ff[ch][15:8];
               end
               default: begin
                  out_ff[ch] <= blend_sum[ch][16] ? 8'hFF : blend_sum[ch][15:8];
               end
            endcase
         end
      end
   end

   assign rsp_bus.valid     = v_ff[NUM_STAGES];
   assign rsp_bus.out_red   = out_ff[0];
   assign rsp_bus.out_green = out_ff[1];
   assign rsp_bus.out_blue  = out_ff[2];
   assign rsp_bus.out_alpha = out_ff[3];

   // The input is held off only when every stage is full and the output stalls.
   `TLAB_ASSERT_IMP(a_ready_tracks_room, clock, reset, 1'b1, req_bus.ready == (rsp_bus.ready || !(&v_ff)))
   // An accepted request always lands in the first stage.
   `TLAB_ASSERT_NEXT(a_accept_enters_pipe, clock, reset, req_bus.valid && req_bus.ready, v_ff[1])

endmodule

/* hdl/tlab_layer.sv */
// ----------------------------------------------------------------------------
// Two-layer alpha blend unit: layer term pipeline
// Five-stage pipeline producing the source contribution of one layer in 8.8.
// ----------------------------------------------------------------------------
module tlab_layer (
   input  logic                   clock,
   input  logic [4:0]             stage_en,
   input  tlab_pkg::pixel_type    pixel,
   input  tlab_pkg::chan_type     plane_alpha,
   input  tlab_pkg::mode_type     mode,
   output tlab_pkg::term_set_type term,
   output tlab_pkg::term_type     ap_term
);

   tlab_pkg::term_type [tlab_pkg::NUM_CH-1:0] x1_ff;
   tlab_pkg::pixel_type                       c1_ff;

   tlab_pkg::term_type [tlab_pkg::NUM_CH-1:0] pre2_ff;
   logic [tlab_pkg::NUM_CH-1:0][31:0]         p2_ff;
   tlab_pkg::pixel_type                       c2_ff;
   tlab_pkg::term_type                        y2_ff;

   tlab_pkg::term_type [tlab_pkg::NUM_CH-1:0] pre3_ff;
   logic [tlab_pkg::NUM_CH-1:0][31:0]         v1_ff;
   tlab_pkg::pixel_type                       c3_ff;
   tlab_pkg::term_type                        y3_ff;

   tlab_pkg::term_type [tlab_pkg::NUM_CH-1:0] pre4_ff;
   logic [tlab_pkg::NUM_CH-1:0][23:0]         v2_ff;
   tlab_pkg::pixel_type                       c4_ff;
   tlab_pkg::term_type                        y4_ff;

   tlab_pkg::term_set_type                    term_ff;
   tlab_pkg::term_type                        y5_ff;

   // Stage 1: colour (or alpha) times plane alpha.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int ch = 0; ch < tlab_pkg::NUM_CH; ch++) begin
            x1_ff[ch] <= 16'(pixel[ch]) * 16'(plane_alpha);
         end
         c1_ff <= pixel;
      end
   end

   // Stage 2: premultiplied term c*P*256/255 = c*P + c*P/255; coverage product.
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int ch = 0; ch < tlab_pkg::NUM_CH; ch++) begin
            pre2_ff[ch] <= x1_ff[ch] + 16'(tlab_pkg::div255(32'(x1_ff[ch])));
            if (ch == tlab_pkg::ALPHA_CH) begin
               p2_ff[ch] <= 32'(x1_ff[tlab_pkg::ALPHA_CH]) * 32'(x1_ff[tlab_pkg::ALPHA_CH]);
            end else begin
               p2_ff[ch] <= 32'(c1_ff[ch]) * 32'(x1_ff[tlab_pkg::ALPHA_CH]);
            end
         end
         c2_ff <= c1_ff;
         y2_ff <= x1_ff[tlab_pkg::ALPHA_CH];
      end
   end

   // Stage 3: first division, folded with the factor of 256.
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         for (int ch = 0; ch < tlab_pkg::NUM_CH; ch++) begin
            v1_ff[ch] <= p2_ff[ch] + 32'(tlab_pkg::div255(p2_ff[ch]));
         end
         pre3_ff <= pre2_ff;
         c3_ff   <= c2_ff;
         y3_ff   <= y2_ff;
      end
   end

   // Stage 4: second division by 255.
   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         for (int ch = 0; ch < tlab_pkg::NUM_CH; ch++) begin
            v2_ff[ch] <= 24'(tlab_pkg::div255(v1_ff[ch]));
         end
         pre4_ff <= pre3_ff;
         c4_ff   <= c3_ff;
         y4_ff   <= y3_ff;
      end
   end

   // Stage 5: third division for coverage alpha, then the mode selection.
   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         for (int ch = 0; ch < tlab_pkg::NUM_CH; ch++) begin
            case (mode)
               tlab_pkg::MODE_PREMULT: begin
                  term_ff[ch] <= pre4_ff[ch];
               end
               tlab_pkg::MODE_COVERAGE: begin
                  if (ch == tlab_pkg::ALPHA_CH) begin
                     term_ff[ch] <= 16'(tlab_pkg::div255(32'(v2_ff[ch])));
                  end else begin
                     term_ff[ch] <= v2_ff[ch][15:0];
                  end
               end
               tlab_pkg::MODE_NONE: begin
                  if (ch == tlab_pkg::ALPHA_CH) begin
                     term_ff[ch] <= tlab_pkg::OPAQUE_88;
                  end else begin
                     term_ff[ch] <= {c4_ff[ch], 8'h00};
                  end
               end
               default: begin
                  term_ff[ch] <= '0;
               end
            endcase
         end
         y5_ff <= y4_ff;
      end
   end

   assign term    = term_ff;
   assign ap_term = y5_ff;

endmodule

/* dv/two_layer_alpha_blend_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-layer alpha blend unit: testbench
// Drives pixel pairs through the request channel under random gaps and
// receiver stalls, and recomputes every composed pixel in fixed point
// alongside the block. Each response is checked channel by channel against
// the oldest outstanding prediction. The register settings are changed only
// once the pipeline has drained.
// ----------------------------------------------------------------------------
module two_layer_alpha_blend_unit_tb;

   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 12;
   // Nine register stages from acceptance to a valid response.
   localparam int PIPE_LATENCY = 9;
   localparam int MAX_REPORTS  = 10;
   localparam int HOLD_CYCLES  = 150;
   localparam int RANDOM_PHASES    = 8;
   localparam int PAIRS_PER_PHASE  = 150;
   localparam int STREAM_PAIRS     = 200;
   localparam int BACKLOG_PAIRS    = 60;

   // Fixed-point scale factors: 255 is one, 255^2 and 255^3 for the products.
   localparam longint unsigned FULL      = 255;
   localparam longint unsigned FULL_CUBE = 16581375;
   localparam longint unsigned SAT_88    = 16'hFFFF;

   logic clock = 1'b0;
   logic reset;

   tlab_req_if req_bus ();
   tlab_rsp_if rsp_bus ();
   tlab_csr_if csr_bus ();

   two_layer_alpha_blend_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Our own copy of the register file, updated on every accepted write.
   tlab_pkg::mode_type top_mode_q;
   tlab_pkg::mode_type bottom_mode_q;
   tlab_pkg::chan_type top_plane_q;
   tlab_pkg::chan_type bottom_plane_q;

   // Composed pixels still owed by the block, oldest first.
   tlab_pkg::pixel_type expected_pixels [$];

   tlab_pkg::mode_type all_modes [4] = '{tlab_pkg::MODE_PREMULT, tlab_pkg::MODE_COVERAGE,
                                         tlab_pkg::MODE_NONE, tlab_pkg::MODE_BYPASS};
   string     chan_names [tlab_pkg::NUM_CH] = '{"red", "green", "blue", "alpha"};

   bit req_gaps_on;
   bit rsp_stalls_on;
   int hold_request;

   int pairs_sent;
   int results_checked;
   int mismatches;
   int register_writes;
   int input_stall_cycles;
   int longest_hold;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Composes one layer onto the 8.8 destination. Bypass leaves the
   // destination untouched; the two blending modes saturate at 0xFFFF.
   function automatic tlab_pkg::term_set_type apply_layer(input tlab_pkg::pixel_type src,
                                                          input tlab_pkg::mode_type mode,
                                                          input tlab_pkg::chan_type plane,
                                                          input tlab_pkg::term_set_type dst);
      longint unsigned        a, p, w, c, term, acc;
      tlab_pkg::term_set_type nxt;
      nxt = dst;
      a   = src[tlab_pkg::ALPHA_CH];
      p   = plane;
      w   = longint'(tlab_pkg::FULL_SQ) - a * p;
      case (mode)
         tlab_pkg::MODE_NONE: begin
            for (int i = 0; i < tlab_pkg::ALPHA_CH; i++) nxt[i] = {src[i], 8'h00};
            nxt[tlab_pkg::ALPHA_CH] = tlab_pkg::OPAQUE_88;
         end
         tlab_pkg::MODE_PREMULT, tlab_pkg::MODE_COVERAGE: begin
            for (int i = 0; i < tlab_pkg::NUM_CH; i++) begin
               c = src[i];
               if (mode == tlab_pkg::MODE_PREMULT)
                  term = (c * p * 256) / FULL;
               else if (i != tlab_pkg::ALPHA_CH)
                  term = (c * a * p * 256) / longint'(tlab_pkg::FULL_SQ);
               else
                  // The coverage alpha is the scaled alpha squared.
                  term = (a * a * p * p * 256) / FULL_CUBE;
               acc    = term + (longint'(dst[i]) * w) / longint'(tlab_pkg::FULL_SQ);
               nxt[i] = (acc > SAT_88) ? tlab_pkg::term_type'(SAT_88)
                                       : tlab_pkg::term_type'(acc);
            end
         end
         default: begin
         end
      endcase
      return nxt;
   endfunction

   // Bottom layer first onto transparent black, then the top layer; the
   // response is the integer part of each 8.8 channel.
   function automatic tlab_pkg::pixel_type compose_pixel(input tlab_pkg::pixel_type top,
                                                         input tlab_pkg::pixel_type bottom);
      tlab_pkg::term_set_type acc;
      tlab_pkg::pixel_type    result;
      acc = '0;
      acc = apply_layer(bottom, bottom_mode_q, bottom_plane_q, acc);
      acc = apply_layer(top, top_mode_q, top_plane_q, acc);
      for (int i = 0; i < tlab_pkg::NUM_CH; i++)
         result[i] = acc[i][tlab_pkg::TERM_W-1:tlab_pkg::CHAN_W];
      return result;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic tlab_pkg::pixel_type rgba(input tlab_pkg::chan_type r,
                                                input tlab_pkg::chan_type g,
                                                input tlab_pkg::chan_type b,
                                                input tlab_pkg::chan_type a);
      tlab_pkg::pixel_type p;
      p[0]                  = r;
      p[1]                  = g;
      p[2]                  = b;
      p[tlab_pkg::ALPHA_CH] = a;
      return p;
   endfunction

   // Channel values lean towards the ends of the range, where the
   // arithmetic is most likely to go wrong.
   function automatic tlab_pkg::chan_type random_channel();
      int pick;
      pick = $urandom_range(0, 7);
      case (pick)
         0:       return '0;
         1:       return '1;
         2:       return tlab_pkg::chan_type'($urandom_range(0, 3));
         3:       return tlab_pkg::chan_type'($urandom_range(252, 255));
         default: return tlab_pkg::chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Each colour channel is kept at or below the alpha (properly premultiplied)
   // half of the time; otherwise it is unconstrained, which exercises saturation.
   function automatic tlab_pkg::pixel_type random_pixel();
      tlab_pkg::pixel_type p;
      p[tlab_pkg::ALPHA_CH] = random_channel();
      for (int i = 0; i < tlab_pkg::ALPHA_CH; i++) begin
         if ($urandom_range(0, 1) == 0)
            p[i] = tlab_pkg::chan_type'($urandom_range(p[tlab_pkg::ALPHA_CH]));
         else
            p[i] = random_channel();
      end
      return p;
   endfunction

   // Gap lengths: mostly drawn from the short range, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Channel drivers
   // -------------------------------------------------------------------------

   // Offers one pixel pair and waits until the block takes it. The
   // prediction is queued at the edge where the request is accepted.
   task automatic send_pair(input tlab_pkg::pixel_type top, input tlab_pkg::pixel_type bottom);
      int n;
      if (req_gaps_on && $urandom_range(0, 99) < 30) begin
         n = gap_length();
         repeat (n) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.top_red      <= top[0];
      req_bus.top_green    <= top[1];
      req_bus.top_blue     <= top[2];
      req_bus.top_alpha    <= top[tlab_pkg::ALPHA_CH];
      req_bus.bottom_red   <= bottom[0];
      req_bus.bottom_green <= bottom[1];
      req_bus.bottom_blue  <= bottom[2];
      req_bus.bottom_alpha <= bottom[tlab_pkg::ALPHA_CH];
      do @(posedge clock); while (!req_bus.ready);
      expected_pixels.push_back(compose_pixel(top, bottom));
      pairs_sent++;
   endtask

   task automatic write_register(input logic [tlab_pkg::CSR_ADDR_W-1:0] index,
                                 input logic [tlab_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         tlab_pkg::REG_TOP_MODE:
            top_mode_q     = tlab_pkg::mode_type'(data[1:0]);
         tlab_pkg::REG_TOP_PLANE_ALPHA:
            top_plane_q    = data;
         tlab_pkg::REG_BOTTOM_MODE:
            bottom_mode_q  = tlab_pkg::mode_type'(data[1:0]);
         tlab_pkg::REG_BOTTOM_PLANE_ALPHA:
            bottom_plane_q = data;
         default: begin
            // Writes to unused indices are dropped by the block.
         end
      endcase
      register_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Lets every outstanding request come back and the pipeline settle, so
   // that a register write cannot affect a pixel already in flight.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic apply_setting(input tlab_pkg::mode_type top_mode,
                                input tlab_pkg::chan_type top_plane,
                                input tlab_pkg::mode_type bottom_mode,
                                input tlab_pkg::chan_type bottom_plane);
      wait_drained();
      write_register(tlab_pkg::REG_TOP_MODE, tlab_pkg::CSR_DATA_W'(top_mode));
      write_register(tlab_pkg::REG_TOP_PLANE_ALPHA, top_plane);
      write_register(tlab_pkg::REG_BOTTOM_MODE, tlab_pkg::CSR_DATA_W'(bottom_mode));
      write_register(tlab_pkg::REG_BOTTOM_PLANE_ALPHA, bottom_plane);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset settings: both layers premultiplied and fully opaque. The pixels
   // cover the range ends, transparent and opaque tops, and colours above
   // their alpha, which overflow the 8.8 intermediate and must saturate.
   task automatic test_corner_pixels();
      send_pair(rgba(0, 0, 0, 0), rgba(0, 0, 0, 0));
      send_pair(rgba(255, 255, 255, 255), rgba(255, 255, 255, 255));
      send_pair(rgba(255, 255, 255, 0), rgba(90, 160, 30, 255));
      send_pair(rgba(18, 52, 86, 255), rgba(200, 10, 100, 128));
      send_pair(rgba(255, 255, 255, 1), rgba(255, 255, 255, 0));
      send_pair(rgba(8'hAA, 8'h55, 8'hAA, 8'h55), rgba(8'h55, 8'hAA, 8'h55, 8'hAA));
   endtask

   // Every pairing of top and bottom mode, bypass included, one pixel each.
   // The plane alphas rotate through opaque, clear, half and the lowest nonzero value.
   task automatic test_blend_modes();
      tlab_pkg::chan_type planes [4];
      planes = '{8'd255, 8'd0, 8'd128, 8'd1};
      for (int t = 0; t < 4; t++) begin
         for (int b = 0; b < 4; b++) begin
            apply_setting(all_modes[t], planes[b], all_modes[b], planes[(t + b) % 4]);
            send_pair(rgba(200, 100, 50, 128), rgba(30, 240, 90, 200));
         end
      end
   endtask

   // A write to an unused index must change nothing, and only the low two
   // bits of a mode write count.
   task automatic test_register_decode();
      logic [tlab_pkg::CSR_ADDR_W-1:0] stray_index;
      stray_index = tlab_pkg::CSR_ADDR_W'($urandom_range(
                       int'(tlab_pkg::REG_BOTTOM_PLANE_ALPHA) + 1,
                       (1 << tlab_pkg::CSR_ADDR_W) - 1));
      apply_setting(tlab_pkg::MODE_COVERAGE, 200, tlab_pkg::MODE_PREMULT, 100);
      write_register(stray_index, tlab_pkg::CSR_DATA_W'($urandom));
      send_pair(rgba(250, 40, 130, 180), rgba(60, 70, 80, 90));
      wait_drained();
      write_register(tlab_pkg::REG_TOP_MODE,
                     {{(tlab_pkg::CSR_DATA_W - 2){1'b1}}, 2'(tlab_pkg::MODE_NONE)});
      send_pair(rgba(17, 34, 51, 68), rgba(255, 0, 255, 255));
   endtask

   // The bulk of the run: several register settings, plane alpha extremes
   // first, each with a long stream of random pixel pairs.
   task automatic test_random_settings();
      tlab_pkg::chan_type tp, bp;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin tp = '1; bp = '1; end
            1:       begin tp = '0; bp = '0; end
            2:       begin tp = 8'd1; bp = 8'd254; end
            default: begin tp = random_channel(); bp = random_channel(); end
         endcase
         apply_setting(all_modes[$urandom_range(0, 3)], tp,
                       all_modes[$urandom_range(0, 3)], bp);
         repeat (PAIRS_PER_PHASE) send_pair(random_pixel(), random_pixel());
      end
   endtask

   // Full rate on both sides: one request per cycle with no stalls at all.
   task automatic test_streaming();
      apply_setting(all_modes[$urandom_range(0, 3)], random_channel(),
                    all_modes[$urandom_range(0, 3)], random_channel());
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      repeat (STREAM_PAIRS) send_pair(random_pixel(), random_pixel());
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the pipeline fills and has to stall its input without losing or
   // repeating a pixel.
   task automatic test_back_pressure();
      apply_setting(tlab_pkg::MODE_COVERAGE, random_channel(),
                    tlab_pkg::MODE_PREMULT, random_channel());
      req_gaps_on  = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (BACKLOG_PAIRS) send_pair(random_pixel(), random_pixel());
      req_gaps_on  = 1'b1;
   endtask

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------

   // Receiver readiness changes on the falling edge only. A requested hold
   // takes priority and is counted down here, one cycle per falling edge.
   initial begin : rsp_ready_driver
      int stall_left;
      int hold_left;
      stall_left    = 0;
      hold_left     = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request > 0) begin
            hold_left    = hold_request - 1;
            longest_hold = hold_request;
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 20) begin
            stall_left = gap_length() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Every accepted response is compared with the oldest prediction.
   always @(posedge clock) begin
      tlab_pkg::pixel_type got;
      tlab_pkg::pixel_type want;
      if (!reset) begin
         if (req_bus.valid && !req_bus.ready)
            input_stall_cycles++;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rgba(rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue,
                       rsp_bus.out_alpha);
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: response %h arrived with no request outstanding",
                           $realtime, got);
            end else begin
               want = expected_pixels.pop_front();
               results_checked++;
               for (int i = 0; i < tlab_pkg::NUM_CH; i++) begin
                  if (got[i] !== want[i]) begin
                     mismatches++;
                     if (mismatches <= MAX_REPORTS)
                        $display("%0t: response %0d, %s expected %0d, got %0d",
                                 $realtime, results_checked, chan_names[i],
                                 want[i], got[i]);
                  end
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sequence of tests
   // -------------------------------------------------------------------------

   initial begin : main_sequence
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.top_red      <= '0;
      req_bus.top_green    <= '0;
      req_bus.top_blue     <= '0;
      req_bus.top_alpha    <= '0;
      req_bus.bottom_red   <= '0;
      req_bus.bottom_green <= '0;
      req_bus.bottom_blue  <= '0;
      req_bus.bottom_alpha <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= '0;
      csr_bus.data         <= '0;
      req_gaps_on          = 1'b1;
      rsp_stalls_on        = 1'b1;
      hold_request         = 0;
      longest_hold         = 0;
      pairs_sent           = 0;
      results_checked      = 0;
      mismatches           = 0;
      register_writes      = 0;
      input_stall_cycles   = 0;

      // Register values the block comes out of reset with.
      top_mode_q     = tlab_pkg::MODE_PREMULT;
      top_plane_q    = '1;
      bottom_mode_q  = tlab_pkg::MODE_PREMULT;
      bottom_plane_q = '1;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_pixels();
      test_blend_modes();
      test_register_decode();
      test_random_settings();
      test_streaming();
      test_back_pressure();

      wait_drained();
      if (expected_pixels.size() != 0) begin
         mismatches++;
         $display("%0d predicted responses never arrived", expected_pixels.size());
      end

      $display("Sent %0d pixel pairs, checked %0d responses, %0d register writes, %0d mismatches.",
               pairs_sent, results_checked, register_writes, mismatches);
      $display("All sixteen mode pairings ran; input stalled for %0d cycles under a %0d-cycle hold.",
               input_stall_cycles, longest_hold);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // A run that hangs on a handshake ends here.
   initial begin : watchdog
      #4_000_000;
      $display("Timed out with %0d responses outstanding", expected_pixels.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
